@@ hdl/plsp_pkg.sv @@
`default_nettype none

package plsp_pkg;

  localparam int unsigned PREFIX_CAPACITY = 30;
  localparam int unsigned CNT_W = $clog2(PREFIX_CAPACITY);
  localparam int unsigned NUM_W = 24;
  localparam int unsigned INDEX_W = 25;
  localparam int unsigned STYLE_W = 3;
  localparam int unsigned LEN_W = 5;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 72;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [NUM_W-1:0] NUM_MAX = '1;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_PRINT_LO = 8'h21;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [7:0] CH_UP_D = 8'h44;
  localparam logic [7:0] CH_UP_R = 8'h52;
  localparam logic [7:0] CH_LO_R = 8'h72;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_LO_A = 8'h61;

  localparam logic [STYLE_W-1:0] STYLE_DEC = 3'd0;
  localparam logic [STYLE_W-1:0] STYLE_ROMAN_UP = 3'd1;
  localparam logic [STYLE_W-1:0] STYLE_ROMAN_LO = 3'd2;
  localparam logic [STYLE_W-1:0] STYLE_ALPHA_UP = 3'd3;
  localparam logic [STYLE_W-1:0] STYLE_ALPHA_LO = 3'd4;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PREFIX = 2'd1,
    KIND_OK     = 2'd2,
    KIND_ERR    = 2'd3
  } plsp_kind_e;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_INDEX,
    PH_STYLE_DONE,
    PH_PREFIX,
    PH_PREFIX_DONE,
    PH_START_NUM,
    PH_PONLY_DONE,
    PH_DISCARD
  } plsp_phase_e;

  typedef struct packed {
    logic                      err;
    logic                      done;
    logic                      at_end;
    logic signed [INDEX_W-1:0] index;
    logic [STYLE_W-1:0]        style;
    logic [NUM_W-1:0]          start;
    logic                      has_prefix;
    logic                      prefix_only;
    logic [CNT_W-1:0]          len;
  } plsp_evt_t;

endpackage

`default_nettype wire

@@ hdl/plsp_parser.sv @@
`default_nettype none

module plsp_parser import plsp_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       char_i,
  input  wire logic [CNT_W-1:0] rd_addr_i,
  output logic [7:0]            rd_byte_o,
  output plsp_evt_t             evt_o
);

  plsp_phase_e               ph_q, ph_d;
  logic                      first_q, first_d;
  logic [NUM_W-1:0]          acc_q, acc_d;
  logic signed [INDEX_W-1:0] index_q, index_d;
  logic [NUM_W-1:0]          start_q, start_d;
  logic [STYLE_W-1:0]        style_q, style_d;
  logic                      has_q, has_d;
  logic                      only_q, only_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic [7:0]                store_q [PREFIX_CAPACITY];
  logic [7:0]                rd_byte_q;

  logic                      is_digit, is_end, sc_ok, is_print, cap_full;
  logic [STYLE_W-1:0]        sc;
  logic [3:0]                dval;
  logic [NUM_W-1:0]          acc_next;
  logic                      err, done, wr_en, restart_now;

  function automatic logic [NUM_W-1:0] accumulate(input logic [NUM_W-1:0] acc,
                                                  input logic [3:0] d);
    logic [NUM_W+3:0] v;
    v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + (NUM_W+4)'(d);
    return (v > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : v[NUM_W-1:0];
  endfunction

  always_comb begin
    sc = STYLE_DEC;
    sc_ok = 1'b1;
    case (char_i)
      CH_UP_D: sc = STYLE_DEC;
      CH_UP_R: sc = STYLE_ROMAN_UP;
      CH_LO_R: sc = STYLE_ROMAN_LO;
      CH_UP_A: sc = STYLE_ALPHA_UP;
      CH_LO_A: sc = STYLE_ALPHA_LO;
      default: sc_ok = 1'b0;
    endcase
  end

  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign is_end = (char_i == CH_UNDERSCORE) || (char_i == CH_NUL);
  assign is_print = (char_i >= CH_PRINT_LO) && (char_i <= CH_PRINT_HI);
  assign cap_full = ({1'b0, cnt_q} + 1'b1) >= (CNT_W+1)'(PREFIX_CAPACITY);
  assign dval = 4'(char_i - CH_ZERO);
  assign acc_next = accumulate(acc_q, dval);

  always_comb begin
    ph_d = ph_q;
    first_d = first_q;
    acc_d = acc_q;
    index_d = index_q;
    start_d = start_q;
    style_d = style_q;
    has_d = has_q;
    only_d = only_q;
    cnt_d = cnt_q;
    err = 1'b0;
    done = 1'b0;
    wr_en = 1'b0;
    restart_now = 1'b0;

    case (ph_q)
      PH_SKIP: begin
        if (char_i == CH_UNDERSCORE) begin
        end else if (char_i == CH_SLASH) begin
          has_d = 1'b1;
          only_d = 1'b1;
          cnt_d = '0;
          ph_d = PH_PREFIX;
        end else if (is_digit) begin
          if (first_q) begin
            err = 1'b1;
          end else begin
            acc_d = NUM_W'(dval);
            ph_d = PH_INDEX;
          end
        end else if (sc_ok) begin
          if (!first_q) begin
            err = 1'b1;
          end else begin
            style_d = sc;
            ph_d = PH_STYLE_DONE;
          end
        end else begin
          err = 1'b1;
        end
      end
      PH_INDEX: begin
        if (is_digit) begin
          acc_d = acc_next;
        end else begin
          index_d = INDEX_W'({1'b0, acc_q}) - INDEX_W'(1);
          acc_d = '0;
          if (sc_ok) begin
            style_d = sc;
            ph_d = PH_STYLE_DONE;
          end else if (is_end) begin
            done = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
      end
      PH_STYLE_DONE: begin
        if (char_i == CH_SLASH) begin
          has_d = 1'b1;
          only_d = 1'b0;
          cnt_d = '0;
          ph_d = PH_PREFIX;
        end else if (is_digit) begin
          acc_d = NUM_W'(dval);
          ph_d = PH_START_NUM;
        end else if (is_end) begin
          done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (char_i == CH_SLASH) begin
          ph_d = only_q ? PH_PONLY_DONE : PH_PREFIX_DONE;
        end else if (cap_full || !is_print) begin
          err = 1'b1;
        end else begin
          wr_en = 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      PH_PREFIX_DONE: begin
        if (is_digit) begin
          acc_d = NUM_W'(dval);
          ph_d = PH_START_NUM;
        end else if (is_end) begin
          done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      PH_START_NUM: begin
        if (is_digit) begin
          acc_d = acc_next;
        end else if (is_end) begin
          start_d = acc_q;
          done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      PH_PONLY_DONE: begin
        if (is_end) begin
          done = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
      PH_DISCARD: begin
        if (char_i == CH_NUL) begin
          restart_now = 1'b1;
        end
      end
      default: begin
        restart_now = 1'b1;
      end
    endcase

    // header carries the range as it stands after this character
    evt_o.err = err;
    evt_o.done = done;
    evt_o.at_end = (char_i == CH_NUL);
    evt_o.index = index_d;
    evt_o.style = style_d;
    evt_o.start = start_d;
    evt_o.has_prefix = has_d;
    evt_o.prefix_only = only_d;
    evt_o.len = cnt_d;

    if (err || done || restart_now) begin
      acc_d = '0;
      index_d = '0;
      start_d = '0;
      style_d = STYLE_DEC;
      has_d = 1'b0;
      only_d = 1'b0;
      cnt_d = '0;
      ph_d = PH_SKIP;
      if (done && char_i != CH_NUL) begin
        first_d = 1'b0;
      end else begin
        first_d = 1'b1;
      end
      if (err && char_i != CH_NUL) begin
        ph_d = PH_DISCARD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PH_SKIP;
      first_q <= 1'b1;
      acc_q <= '0;
      index_q <= '0;
      start_q <= '0;
      style_q <= STYLE_DEC;
      has_q <= 1'b0;
      only_q <= 1'b0;
      cnt_q <= '0;
    end else if (step_i) begin
      ph_q <= ph_d;
      first_q <= first_d;
      acc_q <= acc_d;
      index_q <= index_d;
      start_q <= start_d;
      style_q <= style_d;
      has_q <= has_d;
      only_q <= only_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) begin
      store_q[cnt_q] <= char_i;
    end
  end

  // read is registered: the address is presented in the cycle before the byte is used
  always_ff @(posedge clk_i) begin
    rd_byte_q <= store_q[rd_addr_i];
  end

  assign rd_byte_o = rd_byte_q;

endmodule

`default_nettype wire

@@ hdl/page_label_spec_parser.sv @@
// Page-label spec parser.
// Input stream: one ASCII character per transfer on s_axis; a zero byte
// ends the spec. Output stream: result items on m_axis, kind in tuser,
// tlast set on the last item caused by one input character.
// A character is parsed in the cycle it is accepted and its first result
// (range header or error item) lands in the output register. Plain
// characters go at one per cycle unless the output stalls. A character
// that closes a range with N prefix bytes sends a header and N prefix
// items (and an ok item at end of spec); prefix bytes are read one per
// cycle from the prefix buffer unless output stalls; input is held off.
// After an error a single error item is sent and the rest of the spec up
// to its zero byte is dropped without results.
// Reset (rst_ni low) clears parser state and empties the output register;
// the prefix buffer needs no clearing. When the receiver deasserts
// m_axis_tready the output register holds its item and s_axis_tready
// drops until the output can move again.
`default_nettype none

module page_label_spec_parser import plsp_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // char_in
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // range_index, style, start_value, has_prefix, prefix_only,
  // prefix_length, prefix_byte, zero pad
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  output logic [OUT_TUSER_W-1:0]      m_axis_tuser,  // kind
  output logic                        m_axis_tlast
);

  plsp_evt_t               evt;
  logic [7:0]              rd_byte;
  logic                    accept, slot_free;

  logic                    out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0]  out_data_q, out_data_d;
  plsp_kind_e              out_kind_q, out_kind_d;
  logic                    out_last_q, out_last_d;
  logic                    out_load;

  logic                    burst_q, burst_d;
  logic                    emit_end_q, emit_end_d;
  logic [CNT_W-1:0]        emit_len_q, emit_len_d;
  logic [CNT_W-1:0]        emit_idx_q, emit_idx_d;

  assign slot_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !burst_q && slot_free;
  assign accept = s_axis_tvalid && s_axis_tready;

  plsp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (accept),
    .char_i    (s_axis_tdata),
    .rd_addr_i (emit_idx_d),
    .rd_byte_o (rd_byte),
    .evt_o     (evt)
  );

  always_comb begin
    out_load = 1'b0;
    out_data_d = out_data_q;
    out_kind_d = out_kind_q;
    out_last_d = out_last_q;
    burst_d = burst_q;
    emit_end_d = emit_end_q;
    emit_len_d = emit_len_q;
    emit_idx_d = emit_idx_q;

    if (accept && evt.err) begin
      out_load = 1'b1;
      out_kind_d = KIND_ERR;
      out_data_d = '0;
      out_last_d = 1'b1;
    end else if (accept && evt.done) begin
      out_load = 1'b1;
      out_kind_d = KIND_HEADER;
      out_data_d = {5'b0, 8'b0, LEN_W'(evt.len), evt.prefix_only, evt.has_prefix,
                    evt.start, evt.style, evt.index};
      out_last_d = (evt.len == '0) && !evt.at_end;
      burst_d = (evt.len != '0) || evt.at_end;
      emit_end_d = evt.at_end;
      emit_len_d = evt.len;
      emit_idx_d = '0;
    end else if (burst_q && slot_free) begin
      out_load = 1'b1;
      if (emit_idx_q < emit_len_q) begin
        out_kind_d = KIND_PREFIX;
        out_data_d = {5'b0, rd_byte, 59'b0};
        out_last_d = (emit_idx_q + 1'b1 == emit_len_q) && !emit_end_q;
        emit_idx_d = emit_idx_q + 1'b1;
        burst_d = !((emit_idx_q + 1'b1 == emit_len_q) && !emit_end_q);
      end else begin
        out_kind_d = KIND_OK;
        out_data_d = '0;
        out_last_d = 1'b1;
        burst_d = 1'b0;
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      burst_q <= 1'b0;
      emit_end_q <= 1'b0;
      emit_len_q <= '0;
      emit_idx_q <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      burst_q <= burst_d;
      emit_end_q <= emit_end_d;
      emit_len_q <= emit_len_d;
      emit_idx_q <= emit_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= out_data_d;
      out_kind_q <= out_kind_d;
      out_last_q <= out_last_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_kind_q;
  assign m_axis_tlast = out_last_q;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> emit_idx_q <= emit_len_q)
    else $error("prefix read index past range length");

  a_burst_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_q |-> (emit_end_q || emit_idx_q < emit_len_q))
    else $error("burst active with nothing left to send");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_ERR |-> m_axis_tlast)
    else $error("error item without tlast");

  a_ok_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_OK |-> m_axis_tlast && !burst_q)
    else $error("ok item not closing its burst");
`endif

endmodule

`default_nettype wire

@@ test/page_label_spec_parser_test.sv @@
`default_nettype none

module page_label_spec_parser_test;
  import plsp_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int SPEC_CHARS = 250;

  // tdata layout, lowest field last
  typedef struct packed {
    logic [4:0]                pad;
    logic [7:0]                pbyte;
    logic [LEN_W-1:0]          plen;
    logic                      only;
    logic                      has;
    logic [NUM_W-1:0]          start;
    logic [STYLE_W-1:0]        style;
    logic signed [INDEX_W-1:0] index;
  } label_fields_t;

  typedef struct {
    plsp_kind_e    kind;
    label_fields_t f;
    logic          last;
  } label_item_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;

  page_label_spec_parser DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  // parser shadow state
  plsp_phase_e               spec_phase;
  logic                      first_rng;
  logic [NUM_W-1:0]          num_acc;
  logic signed [INDEX_W-1:0] rng_index;
  logic [NUM_W-1:0]          rng_start;
  logic [STYLE_W-1:0]        rng_style;
  logic                      rng_has;
  logic                      rng_only;
  logic [7:0]                pfx_mem [0:PREFIX_CAPACITY-1];
  int                        pfx_cnt;

  logic [7:0]  spec_chars [$];
  label_item_t label_items_due [$];

  int   chars_total;
  int   chars_taken = 0;
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   in_gap = 0;
  int   out_stall = 0;
  logic in_quiet = 1'b0;
  logic out_quiet = 1'b0;
  logic in_xfer = 1'b0;
  logic out_xfer = 1'b0;

  function automatic logic [NUM_W-1:0] next_number(logic [NUM_W-1:0] a, logic [7:0] c);
    logic [31:0] v;
    v = a * 32'd10 + (c - CH_ZERO);
    return (v > NUM_MAX) ? NUM_MAX : v[NUM_W-1:0];
  endfunction

  task automatic clear_range();
    num_acc = '0;
    rng_index = '0;
    rng_start = '0;
    rng_style = STYLE_DEC;
    rng_has = 1'b0;
    rng_only = 1'b0;
    pfx_cnt = 0;
  endtask

  task automatic restart_spec();
    clear_range();
    first_rng = 1'b1;
    spec_phase = PH_SKIP;
  endtask

  task automatic parse_spec_char(input logic [7:0] c);
    logic        is_end;
    logic        is_dig;
    logic        err;
    logic        done;
    int          sc;
    label_item_t it;
    is_end = (c == CH_UNDERSCORE) || (c == CH_NUL);
    is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
    err = 1'b0;
    done = 1'b0;
    case (c)
      CH_UP_D: sc = STYLE_DEC;
      CH_UP_R: sc = STYLE_ROMAN_UP;
      CH_LO_R: sc = STYLE_ROMAN_LO;
      CH_UP_A: sc = STYLE_ALPHA_UP;
      CH_LO_A: sc = STYLE_ALPHA_LO;
      default: sc = -1;
    endcase
    case (spec_phase)
      PH_SKIP: begin
        if (c == CH_UNDERSCORE) begin
        end else if (c == CH_SLASH) begin
          rng_has = 1'b1;
          rng_only = 1'b1;
          pfx_cnt = 0;
          spec_phase = PH_PREFIX;
        end else if (is_dig) begin
          if (first_rng) err = 1'b1;
          else begin
            num_acc = NUM_W'(c - CH_ZERO);
            spec_phase = PH_INDEX;
          end
        end else if (sc >= 0) begin
          if (!first_rng) err = 1'b1;
          else begin
            rng_style = STYLE_W'(sc);
            spec_phase = PH_STYLE_DONE;
          end
        end else begin
          err = 1'b1;
        end
      end
      PH_INDEX: begin
        if (is_dig) begin
          num_acc = next_number(num_acc, c);
        end else begin
          rng_index = {1'b0, num_acc} - INDEX_W'(1);
          num_acc = '0;
          if (sc >= 0) begin
            rng_style = STYLE_W'(sc);
            spec_phase = PH_STYLE_DONE;
          end else if (is_end) done = 1'b1;
          else err = 1'b1;
        end
      end
      PH_STYLE_DONE: begin
        if (c == CH_SLASH) begin
          rng_has = 1'b1;
          pfx_cnt = 0;
          spec_phase = PH_PREFIX;
        end else if (is_dig) begin
          num_acc = NUM_W'(c - CH_ZERO);
          spec_phase = PH_START_NUM;
        end else if (is_end) done = 1'b1;
        else err = 1'b1;
      end
      PH_PREFIX: begin
        if (c == CH_SLASH) begin
          spec_phase = rng_only ? PH_PONLY_DONE : PH_PREFIX_DONE;
        end else if (pfx_cnt + 1 >= PREFIX_CAPACITY || c < CH_PRINT_LO || c > CH_PRINT_HI) begin
          err = 1'b1;
        end else begin
          pfx_mem[pfx_cnt] = c;
          pfx_cnt++;
        end
      end
      PH_PREFIX_DONE: begin
        if (is_dig) begin
          num_acc = NUM_W'(c - CH_ZERO);
          spec_phase = PH_START_NUM;
        end else if (is_end) done = 1'b1;
        else err = 1'b1;
      end
      PH_START_NUM: begin
        if (is_dig) num_acc = next_number(num_acc, c);
        else if (is_end) begin
          rng_start = num_acc;
          done = 1'b1;
        end else err = 1'b1;
      end
      PH_PONLY_DONE: begin
        if (is_end) done = 1'b1;
        else err = 1'b1;
      end
      default: begin
        if (c == CH_NUL) restart_spec();
        return;
      end
    endcase

    if (err) begin
      it.kind = KIND_ERR;
      it.f = '0;
      it.last = 1'b1;
      label_items_due.push_back(it);
      restart_spec();
      if (c != CH_NUL) spec_phase = PH_DISCARD;
    end else if (done) begin
      it.kind = KIND_HEADER;
      it.f = '0;
      it.f.index = rng_index;
      it.f.style = rng_style;
      it.f.start = rng_start;
      it.f.has = rng_has;
      it.f.only = rng_only;
      it.f.plen = pfx_cnt[LEN_W-1:0];
      it.last = 1'b0;
      label_items_due.push_back(it);
      for (int i = 0; i < pfx_cnt; i++) begin
        it.kind = KIND_PREFIX;
        it.f = '0;
        it.f.pbyte = pfx_mem[i];
        label_items_due.push_back(it);
      end
      if (c == CH_NUL) begin
        it.kind = KIND_OK;
        it.f = '0;
        label_items_due.push_back(it);
        restart_spec();
      end else begin
        clear_range();
        first_rng = 1'b0;
        spec_phase = PH_SKIP;
      end
      label_items_due[label_items_due.size()-1].last = 1'b1;
    end
  endtask

  // stimulus building
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) spec_chars.push_back(s[i]);
  endtask

  task automatic add_prefix();
    int          n;
    logic [7:0]  c;
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(26, 30) : $urandom_range(0, 5);
    spec_chars.push_back(CH_SLASH);
    repeat (n) begin
      do c = 8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)); while (c == CH_SLASH);
      spec_chars.push_back(c);
    end
    spec_chars.push_back(CH_SLASH);
  endtask

  task automatic add_number();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 3);
    repeat (n) spec_chars.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
  endtask

  task automatic add_style();
    case ($urandom_range(0, 4))
      0: spec_chars.push_back(CH_UP_D);
      1: spec_chars.push_back(CH_UP_R);
      2: spec_chars.push_back(CH_LO_R);
      3: spec_chars.push_back(CH_UP_A);
      default: spec_chars.push_back(CH_LO_A);
    endcase
  endtask

  task automatic add_random_spec();
    int first_pos;
    int pos;
    first_pos = spec_chars.size();
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) spec_chars.push_back(CH_UNDERSCORE);
    if ($urandom_range(0, 3) == 0) begin
      add_prefix();
    end else begin
      add_style();
      if ($urandom_range(0, 1)) add_prefix();
      if ($urandom_range(0, 1)) add_number();
    end
    repeat ($urandom_range(0, 3)) begin
      repeat (($urandom_range(0, 5) == 0) ? 2 : 1) spec_chars.push_back(CH_UNDERSCORE);
      if ($urandom_range(0, 3) == 0) begin
        add_prefix();
      end else begin
        add_number();
        if ($urandom_range(0, 2) != 0) begin
          add_style();
          if ($urandom_range(0, 1)) add_prefix();
          if ($urandom_range(0, 1)) add_number();
        end
      end
    end
    // broken specs: random byte, early terminator, trailing separator
    case ($urandom_range(0, 9))
      0, 1: begin
        pos = $urandom_range(first_pos, spec_chars.size() - 1);
        spec_chars[pos] = 8'($urandom_range(0, 255));
      end
      2: begin
        pos = $urandom_range(first_pos, spec_chars.size() - 1);
        spec_chars.insert(pos, CH_NUL);
      end
      3: spec_chars.push_back(CH_UNDERSCORE);
      default: begin
      end
    endcase
    spec_chars.push_back(CH_NUL);
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_xfer)) begin
      if (in_gap > 0) begin
        in_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (spec_chars.size() > 0) begin
        s_axis_tdata <= spec_chars.pop_front();
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 31) == 0) in_quiet = ~in_quiet;
        in_gap = in_quiet ? 0 : $urandom_range(0, 6);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_xfer) begin
        if ($urandom_range(0, 31) == 0) out_quiet = ~out_quiet;
        out_stall = out_quiet ? 0 : $urandom_range(0, 6);
      end
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // monitor: check results first, then predict from the accepted character
  always @(posedge clk_i) begin
    label_item_t   want;
    label_fields_t got;
    logic          in_acc;
    logic          out_acc;
    in_acc = rst_ni && s_axis_tvalid && s_axis_tready;
    out_acc = rst_ni && m_axis_tvalid && m_axis_tready;
    in_xfer <= in_acc;
    out_xfer <= out_acc;
    if (out_acc) begin
      got = m_axis_tdata;
      if (label_items_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transfer: kind %0d data %h last %b",
                   m_axis_tuser, m_axis_tdata, m_axis_tlast);
      end else begin
        want = label_items_due.pop_front();
        if (m_axis_tuser !== want.kind || got.index !== want.f.index ||
            got.style !== want.f.style || got.start !== want.f.start ||
            got.has !== want.f.has || got.only !== want.f.only ||
            got.plen !== want.f.plen || got.pbyte !== want.f.pbyte ||
            got.pad !== want.f.pad || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("mismatch: exp kind %0d idx %0d sty %0d start %0d",
                   want.kind, want.f.index, want.f.style, want.f.start);
            $write(" hp %b po %b len %0d byte %h last %b",
                   want.f.has, want.f.only, want.f.plen, want.f.pbyte, want.last);
            $write(" | got kind %0d idx %0d sty %0d start %0d",
                   m_axis_tuser, got.index, got.style, got.start);
            $display(" hp %b po %b len %0d byte %h pad %h last %b",
                     got.has, got.only, got.plen, got.pbyte, got.pad, m_axis_tlast);
          end
        end
      end
    end
    if (in_acc) begin
      parse_spec_char(s_axis_tdata);
      chars_taken++;
    end
    if (in_acc || out_acc || !rst_ni) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    restart_spec();
    // empty spec
    spec_chars.push_back(CH_NUL);
    // leading underscores, lone style
    add_text("__r");
    spec_chars.push_back(CH_NUL);
    // page 0 range, then trailing separator
    add_text("A/p/9_0R_");
    spec_chars.push_back(CH_NUL);
    // number opening the first range
    add_text("3");
    spec_chars.push_back(CH_NUL);
    // non-printable prefix byte
    add_text("a/");
    spec_chars.push_back(8'h7F);
    spec_chars.push_back(CH_NUL);
    // empty prefix-only range
    add_text("//");
    spec_chars.push_back(CH_NUL);
    // prefix right after a page number
    add_text("D_5/");
    spec_chars.push_back(CH_NUL);
    while (spec_chars.size() < SPEC_CHARS) add_random_spec();
    chars_total = spec_chars.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (chars_taken != chars_total || label_items_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatches == 0 && label_items_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/plsp_pkg.sv
hdl/plsp_parser.sv
hdl/page_label_spec_parser.sv
test/page_label_spec_parser_test.sv
